// File: design/rplr_pkg.sv
// Shared types, constants and the test-pattern function of the RGB plane refresh controller.
package rplr_pkg;

  localparam int LEDS_PER_PLANE_DEF = 128;
  localparam int PAD_BITS_DEF       = 4;
  localparam int DATA_BITS          = 8;
  localparam int ROW_LEDS_LOG2      = 4;
  localparam int ROW_CAP            = 7 * (1 << ROW_LEDS_LOG2);
  localparam int OQ_DEPTH           = 4;

  localparam logic [7:0] START_CODE_RST = 8'hFF;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_BLANK = 2'd2
  } kind_t;

  // color plane codes
  localparam logic [1:0] PLANE_RED   = 2'd0;
  localparam logic [1:0] PLANE_GREEN = 2'd1;
  localparam logic [1:0] PLANE_BLUE  = 2'd2;

  // FET enable codes
  localparam logic [1:0] FET_OFF   = 2'd0;
  localparam logic [1:0] FET_RED   = 2'd1;
  localparam logic [1:0] FET_GREEN = 2'd2;
  localparam logic [1:0] FET_BLUE  = 2'd3;

  typedef struct packed {
    logic       serial_bit;
    logic       clock_pulse;
    logic       last_bit;
    logic       latch_pulse;
    logic       blank_pulse;
    logic [1:0] plane_enabled;
    logic       load_error;
  } rplr_res_t;

  // Power-up test pattern: one color per row of 16 LEDs, white from row six on.
  function automatic logic [7:0] pattern_byte(input logic [2:0] row, input logic [1:0] plane);
    logic [2:0] rgb;
    logic       on;
    unique case (row)
      3'd0:    rgb = 3'b100;
      3'd1:    rgb = 3'b010;
      3'd2:    rgb = 3'b001;
      3'd3:    rgb = 3'b110;
      3'd4:    rgb = 3'b101;
      3'd5:    rgb = 3'b011;
      default: rgb = 3'b111;
    endcase
    unique case (plane)
      PLANE_RED:   on = rgb[2];
      PLANE_GREEN: on = rgb[1];
      PLANE_BLUE:  on = rgb[0];
      default:     on = rgb[2];
    endcase
    return {DATA_BITS{on}};
  endfunction

endpackage

// File: design/rplr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rplr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/rplr_ctrl.sv
// Frame loader, serial shift sequencer and plane control around the frame memory.
module rplr_ctrl #(
  parameter int LEDS_PER_PLANE = rplr_pkg::LEDS_PER_PLANE_DEF,
  parameter int PAD_BITS       = rplr_pkg::PAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  logic                in_take,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_rx_data,
  output logic                s1_valid,
  output rplr_pkg::rplr_res_t s1_res
);
  import rplr_pkg::*;

  localparam int STORE_DEPTH = 3 * LEDS_PER_PLANE;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int WIW         = $clog2(STORE_DEPTH + 1);
  localparam int LW          = (LEDS_PER_PLANE > 1) ? $clog2(LEDS_PER_PLANE) : 1;
  localparam int LED_BITS    = PAD_BITS + DATA_BITS;
  localparam int BIT_W       = $clog2(LED_BITS);

  logic [7:0]     start_code_r, start_code_nxt;
  logic [WIW-1:0] wr_idx_r, wr_idx_nxt;
  logic [WIW-1:0] fill_r, fill_nxt;
  logic           ovf_r, ovf_nxt;
  logic [1:0]     plane_r, plane_nxt;
  logic           lp_r, lp_nxt;
  logic [LW-1:0]  led_r, led_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [1:0]     fet_r, fet_nxt;

  logic           s1_valid_r;
  rplr_res_t      s1_res_r, res_nxt;
  logic           s1_use_mem_r, use_mem_nxt;
  logic [7:0]     s1_pat_r, pat_nxt;
  logic [2:0]     s1_bsel_r, bsel_nxt;

  logic           mem_we, mem_re;
  logic [AW-1:0]  rd_addr;
  logic [1:0]     rd_plane;
  logic [10:0]    led_ext;
  logic [2:0]     row;
  logic [7:0]     mem_rdata;
  logic [7:0]     s1_byte;

  rplr_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx_r[AW-1:0]),
    .wdata (in_rx_data),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // read address and fallback pattern for the current LED and plane
  always_comb begin
    rd_plane = (plane_r == PLANE_RED || plane_r == PLANE_GREEN || plane_r == PLANE_BLUE) ?
               plane_r : PLANE_RED;
    rd_addr  = AW'({led_r, 1'b0}) + AW'(led_r) + AW'(rd_plane);
    led_ext  = 11'(led_r);
    row      = (led_ext >= 11'(ROW_CAP)) ? 3'd6 : led_ext[ROW_LEDS_LOG2 +: 3];
  end

  // next state and result fields for the accepted transaction
  always_comb begin
    start_code_nxt = cfg_valid ? cfg_data : start_code_r;
    wr_idx_nxt     = wr_idx_r;
    fill_nxt       = fill_r;
    ovf_nxt        = ovf_r;
    plane_nxt      = plane_r;
    lp_nxt         = lp_r;
    led_nxt        = led_r;
    bit_nxt        = bit_r;
    fet_nxt        = fet_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    res_nxt        = '0;

    if (in_take) begin
      case (in_kind)
        KIND_BYTE: begin
          if (in_rx_data == start_code_r) begin
            wr_idx_nxt = '0;
            ovf_nxt    = 1'b0;
          end else if (!ovf_r) begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + 1'b1;
            if (wr_idx_nxt >= WIW'(STORE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end
            if (wr_idx_nxt > fill_r) begin
              fill_nxt = wr_idx_nxt;
            end
          end
        end
        KIND_SHIFT: begin
          if (!lp_r) begin
            res_nxt.clock_pulse = 1'b1;
            res_nxt.serial_bit  = (bit_r >= BIT_W'(PAD_BITS));
            mem_re              = 1'b1;
            if (bit_r == BIT_W'(LED_BITS - 1)) begin
              bit_nxt = '0;
              if (led_r == LW'(LEDS_PER_PLANE - 1)) begin
                led_nxt          = '0;
                res_nxt.last_bit = 1'b1;
                lp_nxt           = 1'b1;
              end else begin
                led_nxt = led_r + 1'b1;
              end
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end
        end
        KIND_BLANK: begin
          res_nxt.blank_pulse = 1'b1;
          if (lp_r) begin
            res_nxt.latch_pulse = 1'b1;
            lp_nxt              = 1'b0;
            unique case (plane_r)
              PLANE_RED: begin
                fet_nxt   = FET_RED;
                plane_nxt = PLANE_GREEN;
              end
              PLANE_GREEN: begin
                fet_nxt   = FET_GREEN;
                plane_nxt = PLANE_BLUE;
              end
              PLANE_BLUE: begin
                fet_nxt   = FET_BLUE;
                plane_nxt = PLANE_RED;
              end
              default: begin
                fet_nxt   = FET_OFF;
                plane_nxt = PLANE_RED;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    res_nxt.plane_enabled = fet_nxt;
    res_nxt.load_error    = ovf_nxt;
    use_mem_nxt           = WIW'(rd_addr) < fill_r;
    pat_nxt               = pattern_byte(row, rd_plane);
    bsel_nxt              = 3'(BIT_W'(LED_BITS - 1) - bit_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      wr_idx_r     <= '0;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      plane_r      <= PLANE_RED;
      lp_r         <= 1'b0;
      led_r        <= '0;
      bit_r        <= '0;
      fet_r        <= FET_OFF;
      s1_valid_r   <= 1'b0;
    end else begin
      start_code_r <= start_code_nxt;
      wr_idx_r     <= wr_idx_nxt;
      fill_r       <= fill_nxt;
      ovf_r        <= ovf_nxt;
      plane_r      <= plane_nxt;
      lp_r         <= lp_nxt;
      led_r        <= led_nxt;
      bit_r        <= bit_nxt;
      fet_r        <= fet_nxt;
      s1_valid_r   <= in_take;
    end
  end

  // read-stage payload, captured alongside the memory read
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_res_r     <= res_nxt;
      s1_use_mem_r <= use_mem_nxt;
      s1_pat_r     <= pat_nxt;
      s1_bsel_r    <= bsel_nxt;
    end
  end

  // pick the stored byte or the test pattern, then the addressed bit
  always_comb begin
    s1_byte           = s1_use_mem_r ? mem_rdata : s1_pat_r;
    s1_res            = s1_res_r;
    s1_res.serial_bit = s1_res_r.serial_bit & s1_byte[s1_bsel_r];
  end

  assign s1_valid = s1_valid_r;

  // overflow flag tracks a full write index
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r == (wr_idx_r == WIW'(STORE_DEPTH)))
    else $error("overflow flag out of step with write index");

  // fill count covers every write position
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r >= wr_idx_r && fill_r <= WIW'(STORE_DEPTH))
    else $error("fill count behind write index");

  // a pending latch parks the shift counters at the plane start
  a_lp_park: assert property (@(posedge clk) disable iff (!rst_n)
    lp_r |-> (led_r == '0 && bit_r == '0))
    else $error("shift counters moved while latch pending");

  // memory never reads and writes in one cycle
  a_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("frame memory read and write collide");

endmodule

// File: design/rplr_outq.sv
// Result queue that decouples the read stage from the output channel.
module rplr_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rplr_pkg::rplr_res_t push_data,
  input  logic                pop,
  output logic                head_valid,
  output rplr_pkg::rplr_res_t head_data,
  output logic                room
);
  import rplr_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  rplr_res_t      q_r [OQ_DEPTH];
  logic [PW-1:0]  head_r, head_nxt;
  logic [PW-1:0]  tail_r, tail_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW:0]    level;

  // advance pointers and level
  always_comb begin
    head_nxt = pop  ? head_r + 1'b1 : head_r;
    tail_nxt = push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
    level    = (CW + 1)'(cnt_r) + (CW + 1)'(push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = q_r[head_r];
  // leave a slot for the transaction still in the read stage
  assign room       = level < (CW + 1)'(OQ_DEPTH);

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == CW'(OQ_DEPTH)))
    else $error("result queue overrun");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OQ_DEPTH))
    else $error("result queue level out of range");

endmodule

// File: design/rgb_plane_led_refresh_controller_unit.sv
// RGB plane LED refresh controller: top level.
//
// Input channel (in_valid/in_stall) carries one transaction per cycle when not
// stalled: a received byte (in_kind 0), a serial shift step (1) or a blank tick (2).
// Every accepted transaction produces exactly one result on the output channel
// (out_valid/out_stall): serial bit, clock, last-bit, latch and blank pulses,
// the enabled FET and the frame overflow flag.
// The start code is written through cfg_valid/cfg_data; cfg_ready is always high.
// Each result passes the read stage and then the result queue before it can leave.
// Throughput: one transaction per cycle while in_stall is low; the frame memory
// has one write and one read port and each transaction uses at most one of them.
// Received bytes fill the interleaved R,G,B frame memory; a fill count marks the
// written prefix, and unwritten entries read as the power-up row test pattern,
// so no clearing pass runs and the block accepts input right after reset.
// Reset (rst_n low, synchronous) returns plane to red, FETs off, counters and
// the overflow flag to zero and the start code to 0xFF.
// When the receiver stalls, results collect in a four-entry queue; in_stall
// rises only once that queue, counting the transaction in the read stage, is full.
module rgb_plane_led_refresh_controller_unit #(
  parameter int LEDS_PER_PLANE = rplr_pkg::LEDS_PER_PLANE_DEF,
  parameter int PAD_BITS       = rplr_pkg::PAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_bit,
  output logic       out_clock_pulse,
  output logic       out_last_bit,
  output logic       out_latch_pulse,
  output logic       out_blank_pulse,
  output logic [1:0] out_plane_enabled,
  output logic       out_load_error
);
  import rplr_pkg::*;

  logic      in_take;
  logic      s1_valid;
  rplr_res_t s1_res;
  logic      q_room;
  rplr_res_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = !q_room;
  assign in_take   = in_valid && !in_stall;

  rplr_ctrl #(
    .LEDS_PER_PLANE(LEDS_PER_PLANE),
    .PAD_BITS      (PAD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_take    (in_take),
    .in_kind    (in_kind),
    .in_rx_data (in_rx_data),
    .s1_valid   (s1_valid),
    .s1_res     (s1_res)
  );

  rplr_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid),
    .push_data  (s1_res),
    .pop        (out_valid && !out_stall),
    .head_valid (out_valid),
    .head_data  (head),
    .room       (q_room)
  );

  // drive the result fields from the queue head
  assign out_serial_bit    = head.serial_bit;
  assign out_clock_pulse   = head.clock_pulse;
  assign out_last_bit      = head.last_bit;
  assign out_latch_pulse   = head.latch_pulse;
  assign out_blank_pulse   = head.blank_pulse;
  assign out_plane_enabled = head.plane_enabled;
  assign out_load_error    = head.load_error;

endmodule
